// File: rtl/ohm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ohm_pkg - shared definitions for the open-addressed hash map unit
// Field widths, command and status codes, slot layout and sequencer states.
// ----------------------------------------------------------------------------
package ohm_pkg;

  localparam int MAX_SLOTS_DEF = 1024;

  localparam int CMD_W  = 2;
  localparam int KEY_W  = 31;
  localparam int VAL_W  = 32;
  localparam int ST_W   = 2;
  localparam int SZ_W   = 11;
  localparam int SLOT_W = 1 + KEY_W + VAL_W;

  localparam logic [SZ_W-1:0]  RESET_SIZE = 11'd8;
  localparam logic [VAL_W-1:0] MIN_VALUE  = 32'h8000_0000;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT    = 2'd0,
    CMD_POP    = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_DUP    = 2'd2,
    ST_LIMIT  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_BASE_W,
    S_READ,
    S_CHECK,
    S_STEP_W,
    S_MUL,
    S_ADD,
    S_HASH_W,
    S_COPY,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SCAN_NEXT,
    S_RESP
  } state_t;

endpackage
`default_nettype wire

// File: rtl/ohm_mod_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ohm_mod_unit - iterative remainder unit
// Restoring division, one dividend bit per cycle; only the remainder is kept.
// ----------------------------------------------------------------------------
module ohm_mod_unit #(
  parameter int DW = 34,
  parameter int VW = 12
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic               busy,
  output logic               done,
  output logic [VW-1:0]      remainder
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] dvd;
  logic [VW-1:0] dvs;
  logic [VW-1:0] rem;
  logic [CW-1:0] cnt;
  logic [VW:0]   part;
  logic [VW:0]   diff;
  logic          ge;

  assign part      = {rem, dvd[DW-1]};
  assign diff      = part - {1'b0, dvs};
  assign ge        = part >= {1'b0, dvs};
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
      cnt <= CW'(DW);
    end else if (busy) begin
      // shift in the next dividend bit, subtract when it fits
      rem <= ge ? diff[VW-1:0] : part[VW-1:0];
      dvd <= dvd << 1;
      cnt <= cnt - CW'(1);
    end
  end

endmodule
`default_nettype wire

// File: rtl/open_addressed_resizing_hash_map_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// open_addressed_resizing_hash_map_unit - key/value map with double hashing
// Slot store with open addressing, automatic growth and shrink by rehash.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ channel: s_tuser holds the command (put, pop,
//   search), s_tdata the key and the value. One result per request leaves on
//   the m_ channel: status, value, slot count and occupancy.
//   cfg_data writes the initial slot count and clears the table.
// Operation:
//   The block takes one request at a time. Every probe runs through the
//   single shared remainder unit. A put or pop that resizes adds a copy pass
//   over max(old,new) slots and one re-insert probe sequence per stored pair.
// Reset and configuration:
//   After reset, and after every configuration write, a clearing pass of
//   one slot per cycle over the current slot count runs before requests are
//   taken; configuration writes are taken during it and restart it.
// Stall:
//   The result sits in an output register; a new request is taken while it
//   waits, and the next result holds in the sequencer until it drains.
// ----------------------------------------------------------------------------
module open_addressed_resizing_hash_map_unit #(
  parameter int MAX_SLOTS = ohm_pkg::MAX_SLOTS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // request: key [30:0], value [62:31], zero [63]
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [63:0]            s_tdata,
  // request kind: cmd [1:0]
  input  wire logic [ohm_pkg::CMD_W-1:0] s_tuser,
  // result: status [1:0], result_value [33:2], table_size [44:34],
  // occupancy [55:45]
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [55:0]                 m_tdata,
  // configuration: initial_size
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [ohm_pkg::SZ_W-1:0] cfg_data
);

  localparam int SZW = $clog2(MAX_SLOTS + 1);
  localparam int AW  = $clog2(MAX_SLOTS);
  localparam int TW  = SZW + 2;
  localparam int VW  = SZW + 1;
  localparam int PW  = TW + VW;
  localparam int DW  = (PW + 1 > ohm_pkg::KEY_W) ? PW + 1 : ohm_pkg::KEY_W;
  localparam int CFW = (SZW > ohm_pkg::SZ_W) ? SZW : ohm_pkg::SZ_W;
  localparam int SLW = ohm_pkg::SLOT_W;
  localparam int KW  = ohm_pkg::KEY_W;
  localparam int VLW = ohm_pkg::VAL_W;

  ohm_pkg::state_t state, state_next;

  // slot store and rehash copy
  logic [SLW-1:0] slot_mem [MAX_SLOTS];
  logic [SLW-1:0] scr_mem  [MAX_SLOTS];
  logic [SLW-1:0] slot_rd, scr_rd;
  logic           slot_we, scr_we;
  logic [AW-1:0]  slot_waddr, slot_raddr, scr_waddr, scr_raddr;
  logic [SLW-1:0] slot_wdata, scr_wdata;

  // table bookkeeping
  logic [SZW-1:0] size, fill, i;
  logic [SZW-1:0] rh_old, rh_new, rh_n;
  logic           in_rh;

  // request and probe registers
  ohm_pkg::cmd_t    op_cmd;
  logic [KW-1:0]    op_key;
  logic [VLW-1:0]   op_val;
  logic [AW-1:0]    base, h;
  logic [TW-1:0]    trial;
  logic [VW-1:0]    m;
  logic [PW-1:0]    prod;
  ohm_pkg::status_t resp_status;
  logic [VLW-1:0]   resp_val;

  // remainder unit
  logic          div_go, div_busy, div_done;
  logic [DW-1:0] div_a;
  logic [VW-1:0] div_b, div_rem;

  ohm_mod_unit #(.DW(DW), .VW(VW)) u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (div_go),
    .dividend  (div_a),
    .divisor   (div_b),
    .busy      (div_busy),
    .done      (div_done),
    .remainder (div_rem)
  );

  // handshakes
  logic          acc, cfg_acc, cmd_ok;
  ohm_pkg::cmd_t in_cmd;

  assign cfg_ready = (state == ohm_pkg::S_IDLE) || (state == ohm_pkg::S_CLEAR);
  assign s_tready  = (state == ohm_pkg::S_IDLE) && !cfg_valid;
  assign acc       = s_tvalid && s_tready;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_cmd    = ohm_pkg::cmd_t'(s_tuser);
  assign cmd_ok    = in_cmd inside {ohm_pkg::CMD_PUT, ohm_pkg::CMD_POP, ohm_pkg::CMD_SEARCH};

  // clamp the written size into 1..MAX_SLOTS
  logic [CFW-1:0] cfg_ext;
  logic [SZW-1:0] cfg_size;
  always_comb begin
    cfg_ext = CFW'(cfg_data);
    if (cfg_ext == '0) begin
      cfg_size = SZW'(1);
    end else if (cfg_ext > CFW'(MAX_SLOTS)) begin
      cfg_size = SZW'(MAX_SLOTS);
    end else begin
      cfg_size = SZW'(cfg_ext);
    end
  end

  // probe evaluation on the slot just read
  logic            rd_full;
  logic [KW-1:0]   rd_key;
  logic [VLW-1:0]  rd_val;
  logic [TW-1:0]   trial_inc, limit;
  logic            hit_empty, hit_match, hit_limit, probe_end;

  assign rd_full   = slot_rd[SLW-1];
  assign rd_key    = slot_rd[SLW-2:VLW];
  assign rd_val    = slot_rd[VLW-1:0];
  assign trial_inc = trial + TW'(1);
  assign limit     = {size, 2'b00};
  assign hit_empty = !rd_full;
  assign hit_match = rd_full && (rd_key == op_key);
  assign hit_limit = !hit_empty && !hit_match && (trial_inc >= limit);
  assign probe_end = hit_empty || hit_match || hit_limit;

  // resize decisions
  logic [SZW:0]   dbl;
  logic [SZW-1:0] grow_size, fill_inc, fill_dec, ns_sel, rh_max;
  logic           put_ok, pop_ok, grow, shrink, rh_go;

  assign dbl       = {size, 1'b0};
  assign grow_size = (dbl > (SZW+1)'(MAX_SLOTS)) ? SZW'(MAX_SLOTS) : dbl[SZW-1:0];
  assign fill_inc  = fill + SZW'(1);
  assign fill_dec  = fill - SZW'(1);
  assign put_ok    = !in_rh && (op_cmd == ohm_pkg::CMD_PUT) && hit_empty;
  assign pop_ok    = !in_rh && (op_cmd == ohm_pkg::CMD_POP) && hit_match;
  assign grow      = (fill_inc > (size >> 1)) && (grow_size != size);
  assign shrink    = (fill_dec <= (size >> 2)) && (size > SZW'(7));
  assign rh_go     = (put_ok && grow) || (pop_ok && shrink);
  assign ns_sel    = put_ok ? grow_size : (size >> 1);
  assign rh_max    = (ns_sel > size) ? ns_sel : size;

  logic [SZW-1:0] im1;
  assign im1 = i - SZW'(1);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ohm_pkg::S_CLEAR: begin
        if (cfg_acc) state_next = ohm_pkg::S_CLEAR;
        else if (i == size - SZW'(1)) state_next = ohm_pkg::S_IDLE;
      end
      ohm_pkg::S_IDLE: begin
        if (cfg_acc) state_next = ohm_pkg::S_CLEAR;
        else if (acc) state_next = cmd_ok ? ohm_pkg::S_BASE_W : ohm_pkg::S_RESP;
      end
      ohm_pkg::S_BASE_W: if (div_done) state_next = ohm_pkg::S_READ;
      ohm_pkg::S_READ:   state_next = ohm_pkg::S_CHECK;
      ohm_pkg::S_CHECK: begin
        if (!probe_end) state_next = ohm_pkg::S_STEP_W;
        else if (in_rh) state_next = ohm_pkg::S_SCAN_NEXT;
        else if (rh_go) state_next = ohm_pkg::S_COPY;
        else state_next = ohm_pkg::S_RESP;
      end
      ohm_pkg::S_STEP_W: if (div_done) state_next = ohm_pkg::S_MUL;
      ohm_pkg::S_MUL:    state_next = ohm_pkg::S_ADD;
      ohm_pkg::S_ADD:    state_next = ohm_pkg::S_HASH_W;
      ohm_pkg::S_HASH_W: if (div_done) state_next = ohm_pkg::S_READ;
      ohm_pkg::S_COPY:   if (i == rh_n) state_next = ohm_pkg::S_SCAN_RD;
      ohm_pkg::S_SCAN_RD: state_next = ohm_pkg::S_SCAN_CHK;
      ohm_pkg::S_SCAN_CHK: begin
        state_next = scr_rd[SLW-1] ? ohm_pkg::S_BASE_W : ohm_pkg::S_SCAN_NEXT;
      end
      ohm_pkg::S_SCAN_NEXT: begin
        state_next = (i == rh_old - SZW'(1)) ? ohm_pkg::S_RESP : ohm_pkg::S_SCAN_RD;
      end
      ohm_pkg::S_RESP: if (!m_tvalid || m_tready) state_next = ohm_pkg::S_IDLE;
      default: state_next = ohm_pkg::S_CLEAR;
    endcase
  end

  // memory port control
  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = h;
    slot_wdata = '0;
    slot_raddr = h;
    scr_we     = 1'b0;
    scr_waddr  = im1[AW-1:0];
    scr_wdata  = slot_rd;
    scr_raddr  = i[AW-1:0];
    case (state)
      ohm_pkg::S_CLEAR: begin
        slot_we    = 1'b1;
        slot_waddr = i[AW-1:0];
      end
      ohm_pkg::S_COPY: begin
        // read slot i, move slot i-1 to the copy and empty it
        slot_raddr = i[AW-1:0];
        if (i != '0) begin
          slot_we    = 1'b1;
          slot_waddr = im1[AW-1:0];
          scr_we     = 1'b1;
        end
      end
      ohm_pkg::S_CHECK: begin
        if ((in_rh && hit_empty) || put_ok) begin
          slot_we    = 1'b1;
          slot_wdata = {1'b1, op_key, op_val};
        end else if (pop_ok) begin
          slot_we = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
    slot_rd <= slot_mem[slot_raddr];
  end

  always_ff @(posedge clk) begin
    if (scr_we) scr_mem[scr_waddr] <= scr_wdata;
    scr_rd <= scr_mem[scr_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ohm_pkg::S_CLEAR;
    else     state <= state_next;
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      size     <= SZW'(ohm_pkg::RESET_SIZE);
      fill     <= '0;
      i        <= '0;
      in_rh    <= 1'b0;
      div_go   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      div_go <= 1'b0;
      // drop the result once taken, unless a new one is loaded below
      if (m_tvalid && m_tready && (state != ohm_pkg::S_RESP)) m_tvalid <= 1'b0;
      case (state)
        ohm_pkg::S_CLEAR: begin
          if (cfg_acc) begin
            size <= cfg_size;
            fill <= '0;
            i    <= '0;
          end else begin
            i <= i + SZW'(1);
          end
        end
        ohm_pkg::S_IDLE: begin
          if (cfg_acc) begin
            size <= cfg_size;
            fill <= '0;
            i    <= '0;
          end else if (acc) begin
            op_cmd      <= in_cmd;
            op_key      <= s_tdata[KW-1:0];
            op_val      <= s_tdata[KW+VLW-1:KW];
            in_rh       <= 1'b0;
            resp_status <= ohm_pkg::ST_ABSENT;
            resp_val    <= (in_cmd == ohm_pkg::CMD_PUT) ? '0 : ohm_pkg::MIN_VALUE;
            div_a       <= DW'(s_tdata[KW-1:0]);
            div_b       <= VW'(size);
            div_go      <= cmd_ok;
          end
        end
        ohm_pkg::S_BASE_W: begin
          if (div_done) begin
            base  <= div_rem[AW-1:0];
            h     <= div_rem[AW-1:0];
            trial <= '0;
          end
        end
        ohm_pkg::S_CHECK: begin
          if (!probe_end) begin
            // advance: step = key mod (h/2 + 7)
            trial  <= trial_inc;
            div_a  <= DW'(op_key);
            div_b  <= VW'(h >> 1) + VW'(7);
            div_go <= 1'b1;
          end else if (in_rh) begin
            if (hit_empty) fill <= fill_inc;
          end else begin
            if (op_cmd == ohm_pkg::CMD_PUT) begin
              resp_status <= hit_empty ? ohm_pkg::ST_OK :
                             hit_match ? ohm_pkg::ST_DUP : ohm_pkg::ST_LIMIT;
              if (hit_empty) fill <= fill_inc;
            end else begin
              resp_status <= hit_match ? ohm_pkg::ST_OK :
                             hit_empty ? ohm_pkg::ST_ABSENT : ohm_pkg::ST_LIMIT;
              resp_val    <= hit_match ? rd_val : ohm_pkg::MIN_VALUE;
              if (pop_ok) fill <= fill_dec;
            end
            if (rh_go) begin
              rh_old <= size;
              rh_new <= ns_sel;
              rh_n   <= rh_max;
              i      <= '0;
              in_rh  <= 1'b1;
            end
          end
        end
        ohm_pkg::S_STEP_W: if (div_done) m <= div_rem;
        ohm_pkg::S_MUL:    prod <= trial * m;
        ohm_pkg::S_ADD: begin
          div_a  <= DW'(base) + DW'(prod);
          div_b  <= VW'(size);
          div_go <= 1'b1;
        end
        ohm_pkg::S_HASH_W: if (div_done) h <= div_rem[AW-1:0];
        ohm_pkg::S_COPY: begin
          if (i == rh_n) begin
            size <= rh_new;
            fill <= '0;
            i    <= '0;
          end else begin
            i <= i + SZW'(1);
          end
        end
        ohm_pkg::S_SCAN_CHK: begin
          if (scr_rd[SLW-1]) begin
            op_key <= scr_rd[SLW-2:VLW];
            op_val <= scr_rd[VLW-1:0];
            div_a  <= DW'(scr_rd[SLW-2:VLW]);
            div_b  <= VW'(size);
            div_go <= 1'b1;
          end
        end
        ohm_pkg::S_SCAN_NEXT: i <= i + SZW'(1);
        ohm_pkg::S_RESP: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {ohm_pkg::SZ_W'(fill), ohm_pkg::SZ_W'(size), resp_val, resp_status};
            in_rh    <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // the remainder unit is only started when free
  a_div_free: assert property (@(posedge clk) disable iff (rst) div_go |-> !div_busy)
    else $error("remainder unit started while busy");

  // occupancy never exceeds the slot count
  a_fill_le_size: assert property (@(posedge clk) disable iff (rst) fill <= size)
    else $error("occupancy above slot count");

  // an idle table below the cap is at most half full
  a_load: assert property (@(posedge clk) disable iff (rst)
      (state == ohm_pkg::S_IDLE && size != SZW'(MAX_SLOTS)) |-> fill <= (size >> 1))
    else $error("table left overfull");

  // every probed index lies inside the table
  a_h_range: assert property (@(posedge clk) disable iff (rst)
      state == ohm_pkg::S_READ |-> SZW'(h) < size)
    else $error("probe index out of range");

endmodule
`default_nettype wire
